### src/framed_command_responder_assert.svh
// Assertion macros shared by the responder's modules.
`ifndef FRAMED_COMMAND_RESPONDER_ASSERT_SVH
`define FRAMED_COMMAND_RESPONDER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FCR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fcr_pkg.sv
// Types, codes and helper functions for the framed command responder.
package fcr_pkg;

  // Command and response codes carried in frames.
  localparam logic [7:0] CMD_HEART = 8'h48;
  localparam logic [7:0] CMD_FIRE  = 8'h46;
  localparam logic [7:0] CMD_INFO  = 8'h49;
  localparam logic [7:0] RSP_ACK   = 8'h41;
  localparam logic [7:0] RSP_NACK  = 8'h4E;

  // Frame geometry: five bytes, positions 0 to 4.
  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_CMD   = 3'd1;
  localparam logic [2:0] POS_ARG1  = 3'd2;
  localparam logic [2:0] POS_ARG2  = 3'd3;
  localparam logic [2:0] POS_LAST  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_SYNC_BYTE     = 2'd0;
  localparam logic [1:0] REG_CHECKSUM_SEED = 2'd1;
  localparam logic [1:0] REG_TUBE_COUNT    = 2'd2;

  // Response queue depth, in frames.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       system_ready;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_of_frame;
    logic       fire_request;
    logic [7:0] tube_index;
    logic       heartbeat_seen;
  } out_word_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] checksum_seed;
    logic [7:0] tube_count;
  } cfg_t;

  // One whole response frame, as decided by the front end.
  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] kind;
    logic [7:0] arg0;
    logic [7:0] arg1;
    logic [7:0] sum;
    logic       fire_request;
    logic [7:0] tube_index;
    logic       heartbeat_seen;
  } rsp_t;

  // One step of the shift-xor frame checksum.
  function automatic logic [7:0] fold(input logic [7:0] sum, input logic [7:0] b);
    fold = (sum >> 1) ^ b;
  endfunction

endpackage

### src/framed_command_responder.sv
// Top level of the framed command responder.
// Received words are grouped five at a time into frames (start, command, two
// arguments, checksum) and every frame is answered with a five-word ack or
// nack frame. Both channels run at one word per clock unless stalled: the front
// end takes a word in every cycle it is ready. The first response word is
// written into the queue when the frame's checksum word is taken, then loaded
// into the output register, and the other four follow while out_ready stays
// high. A queue of two response frames sits between the front end and the
// output, so the input stalls only on a checksum word while that queue is
// full. Registers are written through cfg_write, cfg_index and cfg_data;
// index 3 is ignored.
module framed_command_responder (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  fcr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fcr_pkg::out_word_t out_data
);

  fcr_pkg::cfg_t cfg;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_head_valid;
  fcr_pkg::rsp_t q_push_data;
  fcr_pkg::rsp_t q_head_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        fcr_pkg::REG_SYNC_BYTE:     cfg.sync_byte     <= cfg_data;
        fcr_pkg::REG_CHECKSUM_SEED: cfg.checksum_seed <= cfg_data;
        fcr_pkg::REG_TUBE_COUNT:    cfg.tube_count    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fcr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  fcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  fcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### src/fcr_front.sv
// Front end: frames received words, checks them and queues the response.
module fcr_front (
  input  logic             clk,
  input  logic             rst,
  input  fcr_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  fcr_pkg::in_word_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output fcr_pkg::rsp_t    q_data
);

  logic [2:0] pos;
  logic [7:0] checksum;
  logic       header_ok;
  logic [7:0] command_code;
  logic [7:0] second_argument;
  logic       accept;
  logic       at_last;

  logic       good;
  logic       known;
  logic [7:0] sum_a;
  logic [7:0] sum_b;
  logic [7:0] sum_c;

  // Only the checksum word needs room in the queue.
  assign at_last  = (pos == fcr_pkg::POS_LAST);
  assign in_ready = !at_last || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && at_last;

  // Frame position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= fcr_pkg::POS_FIRST;
    end else if (accept) begin
      pos <= at_last ? fcr_pkg::POS_FIRST : pos + 3'd1;
    end
  end

  // Header capture and running checksum.
  always_ff @(posedge clk) begin
    if (accept) begin
      case (pos)
        fcr_pkg::POS_FIRST: begin
          header_ok <= (in_data.rx_byte == cfg.sync_byte);
          checksum  <= fcr_pkg::fold(cfg.checksum_seed, in_data.rx_byte);
        end
        fcr_pkg::POS_CMD: begin
          command_code <= in_data.rx_byte;
          checksum     <= fcr_pkg::fold(checksum, in_data.rx_byte);
        end
        fcr_pkg::POS_ARG1: begin
          checksum <= fcr_pkg::fold(checksum, in_data.rx_byte);
        end
        fcr_pkg::POS_ARG2: begin
          second_argument <= in_data.rx_byte;
          checksum        <= fcr_pkg::fold(checksum, in_data.rx_byte);
        end
        default: begin
        end
      endcase
    end
  end

  // Classify the frame and build the response on its checksum word.
  always_comb begin
    good  = header_ok && (checksum == in_data.rx_byte);
    known = command_code inside {fcr_pkg::CMD_HEART, fcr_pkg::CMD_FIRE,
                                 fcr_pkg::CMD_INFO};
    q_data = '0;
    q_data.sync_byte = cfg.sync_byte;
    if (good && known) begin
      q_data.kind = fcr_pkg::RSP_ACK;
      q_data.arg0 = command_code;
      if (command_code == fcr_pkg::CMD_INFO && in_data.system_ready) begin
        q_data.arg1 = cfg.tube_count;
      end
      if (command_code == fcr_pkg::CMD_HEART) begin
        q_data.heartbeat_seen = 1'b1;
      end
      if (command_code == fcr_pkg::CMD_FIRE) begin
        q_data.fire_request = 1'b1;
        q_data.tube_index   = second_argument;
      end
    end else begin
      q_data.kind = fcr_pkg::RSP_NACK;
      q_data.arg0 = checksum;
      q_data.arg1 = in_data.rx_byte;
    end
    sum_a      = fcr_pkg::fold(cfg.checksum_seed, cfg.sync_byte);
    sum_b      = fcr_pkg::fold(sum_a, q_data.kind);
    sum_c      = fcr_pkg::fold(sum_b, q_data.arg0);
    q_data.sum = fcr_pkg::fold(sum_c, q_data.arg1);
  end

endmodule

### src/fcr_queue.sv
// Short queue of response frames between the front and back ends.
`include "framed_command_responder_assert.svh"

module fcr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fcr_pkg::rsp_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output fcr_pkg::rsp_t head_data
);

  localparam logic [fcr_pkg::QPTR_W-1:0] PTR_LAST =
    fcr_pkg::QPTR_W'(fcr_pkg::QUEUE_DEPTH - 1);
  localparam logic [fcr_pkg::QCNT_W-1:0] CNT_FULL =
    fcr_pkg::QCNT_W'(fcr_pkg::QUEUE_DEPTH);

  fcr_pkg::rsp_t                entries [fcr_pkg::QUEUE_DEPTH];
  logic [fcr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [fcr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [fcr_pkg::QCNT_W-1:0]   count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FCR_ASSERT_SAME(a_no_overflow, push, !full || pop, "push into a full response queue")
  `FCR_ASSERT_SAME(a_no_underflow, pop, head_valid, "pop from an empty response queue")
  `FCR_ASSERT_SAME(a_count_range, 1'b1, count <= CNT_FULL, "response queue count out of range")

endmodule

### src/fcr_back.sv
// Back end: plays each queued response frame out as five words.
`include "framed_command_responder_assert.svh"

module fcr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  fcr_pkg::rsp_t      head_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output fcr_pkg::out_word_t out_data
);

  logic [2:0]         idx;
  logic               load;
  fcr_pkg::out_word_t word;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && (idx == fcr_pkg::POS_LAST);

  // Select the word of the head frame at the current index.
  always_comb begin
    word = '0;
    case (idx)
      fcr_pkg::POS_FIRST: begin
        word.tx_byte        = head_data.sync_byte;
        word.fire_request   = head_data.fire_request;
        word.tube_index     = head_data.tube_index;
        word.heartbeat_seen = head_data.heartbeat_seen;
      end
      fcr_pkg::POS_CMD:  word.tx_byte = head_data.kind;
      fcr_pkg::POS_ARG1: word.tx_byte = head_data.arg0;
      fcr_pkg::POS_ARG2: word.tx_byte = head_data.arg1;
      fcr_pkg::POS_LAST: begin
        word.tx_byte       = head_data.sum;
        word.last_of_frame = 1'b1;
      end
      default: word = '0;
    endcase
  end

  // Word index within the frame being sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= fcr_pkg::POS_FIRST;
    end else if (load) begin
      idx <= (idx == fcr_pkg::POS_LAST) ? fcr_pkg::POS_FIRST : idx + 3'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= word;
    end
  end

  `FCR_ASSERT_SAME(a_last_wraps, out_valid && out_data.last_of_frame,
    idx == fcr_pkg::POS_FIRST, "last word shown without index wrap")
  `FCR_ASSERT_SAME(a_flags_first, out_valid && (out_data.fire_request || out_data.heartbeat_seen),
    idx == fcr_pkg::POS_CMD, "flags shown on a word other than the first")

endmodule
